[hdl/csem_pkg.sv]
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants for the counting semaphore with a waiter queue.
// ----------------------------------------------------------------------------
package csem_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    // configuration port
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLDER_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_HOLDERS = 1'd1;

    // reset values of the configuration registers
    localparam logic [15:0] HOLDER_LIMIT_RST = 16'd1;
    localparam logic [15:0] INIT_HOLDERS_RST = 16'd0;

    // action codes
    localparam logic [1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CANCEL  = 2'd2;

    // result status codes
    typedef enum logic [3:0] {
        STAT_GRANTED  = 4'd0,
        STAT_REFUSED  = 4'd1,
        STAT_QUEUED   = 4'd2,
        STAT_QFULL    = 4'd3,
        STAT_RELEASED = 4'd4,
        STAT_HANDED   = 4'd5,
        STAT_UNDERFLW = 4'd6,
        STAT_REMOVED  = 4'd7,
        STAT_ALREADY  = 4'd8
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HEAD,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // input transaction
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] thread_id;
        logic       no_wait;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [3:0] status;
        logic       woken_valid;
        logic [7:0] woken_thread;
    } t_out_item;

endpackage

[hdl/csem_ram.sv]
// ----------------------------------------------------------------------------
// csem_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/counting_semaphore_fifo_waiters_top.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_top
// Counting semaphore with a first-in first-out queue of waiting threads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries acquire,
//   release and timeout-cancel requests. Each request gives one result
//   transaction on the output channel (o_out_valid / i_out_stall /
//   o_out_data); action code 3 gives none.
//   The block takes one transaction at a time. Acquire and release without
//   waiter are decided in S_DECIDE; release to a waiter also reads the head
//   entry in S_HEAD; timeout cancel scans entries in S_SCAN, then moves each
//   later entry up in S_SHIFT. The next request is taken once the result
//   is in the output register. The steps follow from the single read port
//   of the waiter RAM, walked by a small sequencer with one shared comparator.
//   The waiter queue is a circular buffer; the head pointer moves on release
//   and a cancel closes the gap by copying later entries one slot forward.
//   A finished result sits in an output register; the next input is accepted
//   while it waits, and the sequencer holds its next result until taken.
//   Synchronous reset empties the queue, clears the holder count and
//   restores the holder limit register.
//   The user must issue configuration writes only while the block is idle,
//   unchecked by the block. Writing CFG_INIT_HOLDERS sets the holder count.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top #(
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  csem_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output csem_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [csem_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [csem_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import csem_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (THREAD_ID_BITS < 8) ? THREAD_ID_BITS : 8;
    localparam logic [7:0] TID_MASK = 8'((1 << TW) - 1);

    // circular buffer position of a logical queue index
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state      r_state, n_state;
    logic [1:0]  r_action, n_action;
    logic [7:0]  r_tid, n_tid;
    logic        r_nowait, n_nowait;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_occ, n_occ;
    logic [AW-1:0] r_head, n_head;
    logic [15:0] r_holder, n_holder;
    logic [15:0] r_holder_limit;
    t_status     r_status, n_status;
    logic        r_wv, n_wv;
    logic [7:0]  r_wt, n_wt;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;

    logic          ram_we;
    logic [AW-1:0] ram_wlog;
    logic [AW-1:0] ram_rlog;
    logic [TW-1:0] ram_wdata;
    logic [TW-1:0] ram_rdata;
    logic [CW:0]   w_idx_p1;
    logic [CW:0]   w_idx_p2;
    logic [CW:0]   w_occ_x;
    logic [AW-1:0] w_head_p1;

    // waiter storage
    csem_ram #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (f_phys(r_head, ram_wlog)),
        .i_wdata (ram_wdata),
        .i_raddr (f_phys(r_head, ram_rlog)),
        .o_rdata (ram_rdata)
    );

    // index arithmetic
    assign w_idx_p1  = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx_p2  = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_occ_x   = (CW+1)'(r_occ);
    assign w_head_p1 = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);

    // sequencer state register and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
            r_holder    <= INIT_HOLDERS_RST;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == CFG_INIT_HOLDERS) begin
                r_holder <= i_cfg_data;
            end else begin
                r_holder <= n_holder;
            end
        end
        r_action   <= n_action;
        r_tid      <= n_tid;
        r_nowait   <= n_nowait;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_wv       <= n_wv;
        r_wt       <= n_wt;
        r_out_data <= n_out_data;
    end

    // holder limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holder_limit <= HOLDER_LIMIT_RST;
        end else if (i_cfg_we && i_cfg_index == CFG_HOLDER_LIMIT) begin
            r_holder_limit <= i_cfg_data;
        end
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_tid       = r_tid;
        n_nowait    = r_nowait;
        n_idx       = r_idx;
        n_occ       = r_occ;
        n_head      = r_head;
        n_holder    = r_holder;
        n_status    = r_status;
        n_wv        = r_wv;
        n_wt        = r_wt;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_wlog    = '0;
        ram_rlog    = '0;
        ram_wdata   = r_tid[TW-1:0];

        case (r_state)
            // take a new transaction
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_in_data.action;
                    n_tid    = i_in_data.thread_id & TID_MASK;
                    n_nowait = i_in_data.no_wait;
                    n_state  = S_DECIDE;
                end
            end

            // count and occupancy decisions, first queue access
            S_DECIDE: begin
                n_wv = 1'b0;
                n_wt = '0;
                case (r_action)
                    ACT_ACQUIRE: begin
                        n_state = S_DONE;
                        if (r_holder < r_holder_limit) begin
                            n_holder = r_holder + 16'd1;
                            n_status = STAT_GRANTED;
                        end else if (r_nowait) begin
                            n_status = STAT_REFUSED;
                        end else if (r_occ == CW'(QUEUE_DEPTH)) begin
                            n_status = STAT_QFULL;
                        end else begin
                            ram_we   = 1'b1;
                            ram_wlog = AW'(r_occ);
                            n_occ    = r_occ + CW'(1);
                            n_status = STAT_QUEUED;
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_occ != '0) begin
                            ram_rlog = '0;
                            n_state  = S_HEAD;
                        end else if (r_holder == 16'd0) begin
                            n_status = STAT_UNDERFLW;
                            n_state  = S_DONE;
                        end else begin
                            n_holder = r_holder - 16'd1;
                            n_status = STAT_RELEASED;
                            n_state  = S_DONE;
                        end
                    end
                    ACT_CANCEL: begin
                        if (r_occ != '0) begin
                            ram_rlog = '0;
                            n_idx    = '0;
                            n_state  = S_SCAN;
                        end else begin
                            n_status = STAT_ALREADY;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // hand the slot to the oldest waiter
            S_HEAD: begin
                n_wv     = 1'b1;
                n_wt     = 8'(ram_rdata);
                n_head   = w_head_p1;
                n_occ    = r_occ - CW'(1);
                n_status = STAT_HANDED;
                n_state  = S_DONE;
            end

            // search for the named thread, one entry per cycle
            S_SCAN: begin
                if (ram_rdata == r_tid[TW-1:0]) begin
                    n_status = STAT_REMOVED;
                    if (w_idx_p1 < w_occ_x) begin
                        ram_rlog = AW'(w_idx_p1);
                        n_state  = S_SHIFT;
                    end else begin
                        n_occ   = r_occ - CW'(1);
                        n_state = S_DONE;
                    end
                end else if (w_idx_p1 < w_occ_x) begin
                    ram_rlog = AW'(w_idx_p1);
                    n_idx    = AW'(w_idx_p1);
                end else begin
                    n_status = STAT_ALREADY;
                    n_state  = S_DONE;
                end
            end

            // close the gap: move each later entry one slot forward
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_wlog  = r_idx;
                ram_wdata = ram_rdata;
                if (w_idx_p2 < w_occ_x) begin
                    ram_rlog = AW'(w_idx_p2);
                    n_idx    = AW'(w_idx_p1);
                end else begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.status       = r_status;
                    n_out_data.woken_valid  = r_wv;
                    n_out_data.woken_thread = r_wt;
                    n_state                 = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
